[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the core, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");
// Check that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    `ASSERT_PROP(label, clk, rst_n, expr)
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`endif
`endif

[rtl/core/sptro_pkg.sv]
// Types, constants and codes shared by the read offset lookup core.
package sptro_pkg;

    localparam int MAX_READS  = 1024;
    localparam int IDX_W      = $clog2(MAX_READS);
    localparam int CNT_W      = $clog2(MAX_READS + 1);
    localparam int LEN_W      = 16;
    localparam int POS_W      = 32;
    localparam int MIN_W      = 16;
    localparam int OUT_IDX_W  = 10;
    localparam logic [MIN_W-1:0] MIN_SUFFIX_RESET = 16'd30;

    localparam int IN_TDATA_W  = ((LEN_W + POS_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = OUT_IDX_W + POS_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BEYOND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_FINISH = 2'd2
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic search;
        logic finish;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic query_go;
        logic search_done;
    } t_dp_stat;

endpackage

[rtl/core/sptro_dp.sv]
// Datapath: read tables, running totals, binary search registers and result register.
module sptro_dp
    import sptro_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_dp_stat             o_stat,
    input  logic [1:0]           i_req_type,
    input  logic [LEN_W-1:0]     i_read_length,
    input  logic [POS_W-1:0]     i_position,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MIN_W-1:0]     i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [OUT_IDX_W-1:0] o_read_index,
    output logic [POS_W-1:0]     o_offset,
    output logic                 o_keep,
    output logic [1:0]           o_status
);

    logic [POS_W-1:0] mem_start [MAX_READS];
    logic [LEN_W-1:0] mem_len   [MAX_READS];

    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_total;
    logic [MIN_W-1:0] r_min;
    logic             r_out_valid;

    logic [POS_W-1:0] r_rd_start;
    logic [LEN_W-1:0] r_rd_len;
    logic [CNT_W-1:0] r_lo, r_hi, r_mid;
    logic [CNT_W-1:0] n_lo, n_hi, n_mid;
    logic [POS_W-1:0] r_pos;
    logic [IDX_W-1:0] r_idx;
    logic [POS_W-1:0] r_off;
    logic [LEN_W-1:0] r_len;

    logic [OUT_IDX_W-1:0] r_out_idx;
    logic [POS_W-1:0]     r_out_off;
    logic                 r_out_keep;
    t_status              r_out_status;

    t_req             req;
    logic [POS_W:0]   sum_total;
    logic             full;
    logic             do_clear;
    logic             do_append;
    logic             query_go;
    logic [OUT_IDX_W-1:0] d_idx;
    logic [POS_W-1:0] d_off;
    t_status          d_status;
    logic             probe_le;
    logic [CNT_W-1:0] init_mid;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             keep_calc;
    logic             load_direct;
    logic             out_free;

    assign req       = t_req'(i_req_type);
    assign sum_total = {1'b0, r_total} + (POS_W + 1)'(i_read_length);
    assign full      = (r_count == CNT_W'(MAX_READS)) || sum_total[POS_W];

    // result of items that finish at acceptance
    always_comb begin
        do_clear  = 1'b0;
        do_append = 1'b0;
        query_go  = 1'b0;
        d_idx     = '0;
        d_off     = '0;
        d_status  = ST_OK;
        unique case (req)
            REQ_CLEAR: begin
                do_clear = 1'b1;
            end
            REQ_APPEND: begin
                if (full) begin
                    d_status = ST_FULL;
                end else begin
                    do_append = 1'b1;
                    d_idx     = OUT_IDX_W'(r_count);
                    d_off     = r_total;
                end
            end
            REQ_QUERY: begin
                if (r_count == '0) begin
                    d_status = ST_EMPTY;
                end else if (i_position >= r_total) begin
                    d_status = ST_BEYOND;
                end else begin
                    query_go = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // one probe per cycle; the next address comes straight from the updated bounds
    assign probe_le  = (r_rd_start <= r_pos);
    assign n_lo      = probe_le ? (r_mid + CNT_W'(1)) : r_lo;
    assign n_hi      = probe_le ? r_hi : r_mid;
    assign n_mid     = n_lo + ((n_hi - n_lo) >> 1);
    assign init_mid  = r_count >> 1;
    assign rd_addr   = i_cmd.search ? n_mid[IDX_W-1:0] : init_mid[IDX_W-1:0];
    assign wr_addr   = r_count[IDX_W-1:0];
    assign keep_calc = (({1'b0, r_off} + (POS_W + 1)'(r_min)) < (POS_W + 1)'(r_len));

    assign load_direct = i_cmd.accept && !query_go;
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && do_append) begin
            mem_start[wr_addr] <= r_total;
            mem_len[wr_addr]   <= i_read_length;
        end
        r_rd_start <= mem_start[rd_addr];
        r_rd_len   <= mem_len[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_total     <= '0;
            r_min       <= MIN_SUFFIX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_min <= i_cfg_data;
            end
            if (i_cmd.accept && do_clear) begin
                r_count <= '0;
                r_total <= '0;
            end else if (i_cmd.accept && do_append) begin
                r_count <= r_count + CNT_W'(1);
                r_total <= sum_total[POS_W-1:0];
            end
            if (load_direct || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && query_go) begin
            r_lo  <= '0;
            r_hi  <= r_count;
            r_mid <= init_mid;
            r_pos <= i_position;
        end else if (i_cmd.search) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_mid;
            // latest read starting at or below the position is the candidate
            if (probe_le) begin
                r_idx <= r_mid[IDX_W-1:0];
                r_off <= r_pos - r_rd_start;
                r_len <= r_rd_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_direct) begin
            r_out_idx    <= d_idx;
            r_out_off    <= d_off;
            r_out_keep   <= 1'b0;
            r_out_status <= d_status;
        end else if (i_cmd.finish) begin
            r_out_idx    <= OUT_IDX_W'(r_idx);
            r_out_off    <= r_off;
            r_out_keep   <= keep_calc;
            r_out_status <= ST_OK;
        end
    end

    assign o_stat.out_free    = out_free;
    assign o_stat.query_go    = query_go;
    assign o_stat.search_done = (n_lo >= n_hi);

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_read_index = r_out_idx;
    assign o_offset     = r_out_off;
    assign o_keep       = r_out_keep;
    assign o_status     = r_out_status;

endmodule

[rtl/core/sptro_ctrl.sv]
// Controller state machine: accept, search sequencing and result hand-off.
module sptro_ctrl
    import sptro_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.out_free && i_stat.query_go) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.search_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE) && i_stat.out_free;
        o_cmd.accept = i_in_valid && o_in_ready;
        o_cmd.search = (r_state == S_SEARCH);
        o_cmd.finish = (r_state == S_FINISH) && i_stat.out_free;
    end

endmodule

[rtl/core/suffix_position_to_read_offset_core.sv]
// Top level of the read offset lookup core: ports, field packing and checks.
//
// Keeps a table of reads laid end to end in one text. Items arrive on the
// s_axis channel; tuser carries the request (clear, append, query). Append
// stores the read length and its start (running total of earlier lengths)
// and returns the new index and start. Query returns the read holding the
// position, the offset inside it and a keep flag (suffix longer than the
// minimum set through the cfg channel, reset value 30).
// Clear, append, error results and unused requests load the result register
// on the accept edge, so m_axis_tvalid rises in the cycle after acceptance. A query runs a
// predecessor binary search with one table probe per cycle through the
// registered read port of the start/length memories: ceil(log2(count+1))
// probes, at most 11 for 1024 reads, then a finish step that loads the result
// register once it is free; the next item is taken once the result is
// delivered or the output register frees.
// A stalled receiver holds the result register; s_axis_tready drops until
// the slot frees. Reset empties the table (count and total to zero) and
// needs no clearing pass; table entries past the count are never used.
module suffix_position_to_read_offset_core
    import sptro_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request item
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // read_length[15:0], position[47:16]
    input  logic [1:0]             s_axis_tuser,   // req_type[1:0]
    // result item
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // read_index[9:0], offset[41:10],
                                                   // keep[42], zero pad[47:43]
    output logic [1:0]             m_axis_tuser,   // status[1:0]
    // minimum suffix length register
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [MIN_W-1:0]       i_cfg_data
);

`include "assert_macros.svh"

    t_cmd     dp_cmd;
    t_dp_stat dp_stat;

    logic [OUT_IDX_W-1:0] out_idx;
    logic [POS_W-1:0]     out_off;
    logic                 out_keep;

    sptro_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sptro_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_req_type    (s_axis_tuser),
        .i_read_length (s_axis_tdata[LEN_W-1:0]),
        .i_position    (s_axis_tdata[LEN_W+POS_W-1:LEN_W]),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_read_index  (out_idx),
        .o_offset      (out_off),
        .o_keep        (out_keep),
        .o_status      (m_axis_tuser)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_keep, out_off, out_idx};

    // an accepted item always finds the result slot free by the next edge
    `ASSERT_PROP(a_accept_slot_free, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tready))
    // a query that starts a search blocks the input on the next cycle
    `ASSERT_PROP(a_search_blocks_input, i_clk, i_rst_n, (dp_cmd.accept && dp_stat.query_go) |=> !s_axis_tready)
    // finishing a search puts a result on the output
    `ASSERT_PROP(a_finish_shows_result, i_clk, i_rst_n, dp_cmd.finish |=> m_axis_tvalid)
    // accept, search step and finish never overlap
    `ASSERT_ALWAYS(a_cmd_exclusive, i_clk, i_rst_n, $onehot0({dp_cmd.accept, dp_cmd.search, dp_cmd.finish}))

endmodule

[test/sptro_lookup_checker.sv]
// Checker for the read offset lookup core: tracks the read table, predicts results, compares.
module sptro_lookup_checker
    import sptro_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // read_length[15:0], position[47:16]
    input  logic [1:0]             s_axis_tuser,   // req_type[1:0]
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // read_index[9:0], offset[41:10], keep[42]
    input  logic [1:0]             m_axis_tuser,   // status[1:0]
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [MIN_W-1:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [OUT_IDX_W-1:0] read_index;
        logic [POS_W-1:0]     offset;
        logic                 keep;
        t_status              status;
    } t_lookup_result;

    // own copy of the read table and the minimum length register
    logic [POS_W-1:0] start_of_read [MAX_READS];
    logic [LEN_W-1:0] len_of_read   [MAX_READS];
    int unsigned      n_reads;
    logic [POS_W-1:0] text_len;
    logic [MIN_W-1:0] min_keep_len;

    t_lookup_result   expected_lookups [$];
    int               mismatches = 0;
    int               n_results  = 0;

    // Apply one request to the table copy and return the result it must produce.
    function automatic t_lookup_result apply_request(input logic [1:0] req,
                                                     input logic [LEN_W-1:0] len,
                                                     input logic [POS_W-1:0] pos);
        t_lookup_result r = '0;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        int unsigned    hit;
        r.status = ST_OK;
        case (req)
            REQ_CLEAR: begin
                n_reads  = 0;
                text_len = '0;
            end
            REQ_APPEND: begin
                if (n_reads >= MAX_READS || ({1'b0, text_len} + len) > {1'b0, 32'hFFFF_FFFF}) begin
                    r.status = ST_FULL;
                end else begin
                    start_of_read[n_reads] = text_len;
                    len_of_read[n_reads]   = len;
                    r.read_index = OUT_IDX_W'(n_reads);
                    r.offset     = text_len;
                    text_len     = text_len + len;
                    n_reads      = n_reads + 1;
                end
            end
            REQ_QUERY: begin
                if (n_reads == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= text_len) begin
                    r.status = ST_BEYOND;
                end else begin
                    // last read whose start is at or below the position
                    lo = 0;
                    hi = n_reads;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if (start_of_read[mid] <= pos) lo = mid + 1;
                        else hi = mid;
                    end
                    hit          = lo - 1;
                    r.read_index = OUT_IDX_W'(hit);
                    r.offset     = pos - start_of_read[hit];
                    r.keep       = (34'(r.offset) + 34'(min_keep_len)) < 34'(len_of_read[hit]);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [POS_W-1:0] want,
                                 input logic [POS_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH result %0d, %s: expected 0x%0h, got 0x%0h",
                     n_results, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_lookup_result got;
        t_lookup_result want;
        if (!i_rst_n) begin
            n_reads      = 0;
            text_len     = '0;
            min_keep_len = MIN_SUFFIX_RESET;
            expected_lookups.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                min_keep_len = i_cfg_data;
            // retire before predicting: a result never leaves on its own accept edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.read_index = m_axis_tdata[OUT_IDX_W-1:0];
                got.offset     = m_axis_tdata[OUT_IDX_W +: POS_W];
                got.keep       = m_axis_tdata[OUT_IDX_W + POS_W];
                got.status     = t_status'(m_axis_tuser);
                n_results++;
                if (expected_lookups.size() == 0) begin
                    flag_mismatch("result with nothing pending, offset", '0, got.offset);
                end else begin
                    want = expected_lookups.pop_front();
                    if (got.read_index !== want.read_index)
                        flag_mismatch("read_index", POS_W'(want.read_index),
                                      POS_W'(got.read_index));
                    if (got.offset !== want.offset)
                        flag_mismatch("offset", want.offset, got.offset);
                    if (got.keep !== want.keep)
                        flag_mismatch("keep", POS_W'(want.keep), POS_W'(got.keep));
                    if (got.status !== want.status)
                        flag_mismatch("status", POS_W'(want.status), POS_W'(got.status));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_lookups.insert(expected_lookups.size(),
                                        apply_request(s_axis_tuser,
                                                      s_axis_tdata[LEN_W-1:0],
                                                      s_axis_tdata[LEN_W +: POS_W]));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_lookups.size();
    end

endmodule

[test/tb_top.sv]
// Testbench top for the read offset lookup core: clock, reset, stimulus and verdict.
module tb_top;
    import sptro_pkg::*;

    localparam logic [1:0] REQ_UNUSED        = 2'd3;
    localparam int         HOLD_OFF_CYCLES    = 300;
    localparam int         DRAIN_CYCLES       = 20;
    localparam int         RANDOM_PER_SETTING = 20;
    localparam int         N_SETTINGS         = 5;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // read_length[15:0], position[47:16]
    logic [1:0]             s_axis_tuser  = '0;   // req_type[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // read_index[9:0], offset[41:10], keep[42]
    logic [1:0]             m_axis_tuser;         // status[1:0]
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [MIN_W-1:0]       i_cfg_data    = '0;

    int                     fail_count;
    int                     results_pending;

    // idling shares, in percent of cycles
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;

    // receiver hold-off request: a toggle seen by the receiver process
    logic                   rx_hold_tog  = 1'b0;
    logic                   rx_hold_seen = 1'b0;
    int                     rx_hold_left = 0;

    // stimulus-side view of the table, used only to aim queries
    int unsigned            stim_starts [$];
    int unsigned            stim_lens   [$];
    logic [POS_W-1:0]       stim_total   = '0;
    logic [MIN_W-1:0]       min_setting  = MIN_SUFFIX_RESET;

    int                     n_items   = 0;
    int                     n_appends = 0;
    int                     n_queries = 0;
    int                     n_clears  = 0;
    int                     n_unused  = 0;

    suffix_position_to_read_offset_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    sptro_lookup_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (results_pending)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stall at random, or hold off for a long counted stretch on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= 0;
            rx_hold_seen  <= rx_hold_tog;
        end else if (rx_hold_tog != rx_hold_seen) begin
            rx_hold_seen  <= rx_hold_tog;
            rx_hold_left  <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Give up on a hung run: many times the slowest expected run length.
    initial begin
        #10_000_000;
        $display("timeout: %0d results still pending", results_pending);
        $display("** suffix_position_to_read_offset_core: FAILED **");
        $finish;
    end

    // Offer one item, idling first at random, and hold it until accepted.
    task automatic send_request(input logic [1:0] req, input logic [LEN_W-1:0] len,
                                input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {pos, len};
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;
        case (req)
            REQ_CLEAR:  n_clears++;
            REQ_APPEND: n_appends++;
            REQ_QUERY:  n_queries++;
            default:    n_unused++;
        endcase
    endtask

    task automatic clear_table();
        send_request(REQ_CLEAR, LEN_W'($urandom), $urandom);
        stim_starts.delete();
        stim_lens.delete();
        stim_total = '0;
    endtask

    // Append a read; track it only while the table has room (a full table drops it).
    task automatic append_read(input logic [LEN_W-1:0] len);
        send_request(REQ_APPEND, len, $urandom);
        if (stim_starts.size() < MAX_READS) begin
            stim_starts.insert(stim_starts.size(), stim_total);
            stim_lens.insert(stim_lens.size(), len);
            stim_total = stim_total + len;
        end
    endtask

    // Query inside the text, mostly on read edges and on the keep threshold.
    task automatic query_in_text();
        int unsigned      r;
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] l;
        logic [POS_W-1:0] pos;
        if (stim_starts.size() == 0 || stim_total == 0) begin
            pos = $urandom_range(3);
        end else if ($urandom_range(2) == 0) begin
            pos = $urandom_range(stim_total - 1, 0);
        end else begin
            r    = $urandom_range(stim_starts.size() - 1);
            base = stim_starts[r];
            l    = stim_lens[r];
            case ($urandom_range(4))
                0:       pos = base;
                1:       pos = base + l - 1;
                2:       pos = base + l - min_setting - 1;
                3:       pos = base + l - min_setting;
                default: pos = base + $urandom_range(l);
            endcase
        end
        send_request(REQ_QUERY, LEN_W'($urandom), pos);
    endtask

    // Drop valid, wait until every result is back, then let the pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the minimum suffix length while the core is idle.
    task automatic set_min_len(input logic [MIN_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        min_setting = v;
    endtask

    // Well-formed runs (clear, appends, queries inside the text) plus noise.
    task automatic run_random(input int n);
        int pick;
        clear_table();
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 30)
                append_read(($urandom_range(7) == 0) ? LEN_W'($urandom)
                                                     : LEN_W'($urandom_range(200)));
            else if (pick < 78)
                query_in_text();
            else if (pick < 86)
                send_request(REQ_QUERY, LEN_W'($urandom), $urandom);
            else if (pick < 92)
                clear_table();
            else
                send_request(REQ_UNUSED, LEN_W'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [MIN_W-1:0] min_settings [N_SETTINGS];

        min_settings = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd30};
        min_settings[3] = MIN_W'($urandom);

        // Hold reset low, then release it.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with the reset value of the minimum length (30).
        send_request(REQ_QUERY, '0, '0);                   // empty table
        send_request(REQ_UNUSED, 16'h5A5A, 32'hA5A5_A5A5); // unused code is a no-op
        clear_table();
        append_read(16'd30);       // not longer than the minimum: never kept
        append_read(16'd0);        // zero length: holds no position
        append_read(16'd31);
        append_read(16'hFFFF);
        append_read(16'd1);
        send_request(REQ_QUERY, '0, 32'd0);
        send_request(REQ_QUERY, '0, 32'd29);
        send_request(REQ_QUERY, '0, 32'd30);               // skips the zero-length read
        send_request(REQ_QUERY, '0, 32'd31);
        send_request(REQ_QUERY, '0, 32'd60);
        send_request(REQ_QUERY, 16'hFFFF, 32'd61);
        send_request(REQ_QUERY, '0, stim_total - 1);
        send_request(REQ_QUERY, '0, stim_total);           // first position past the end
        send_request(REQ_QUERY, '0, 32'hFFFF_FFFF);
        append_read(16'd0);                                // trailing zero-length read
        send_request(REQ_QUERY, '0, stim_total - 1);
        send_request(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(REQ_APPEND, 16'hFFFF, 32'hFFFF_FFFF);
        stim_starts.insert(stim_starts.size(), stim_total);
        stim_lens.insert(stim_lens.size(), 16'hFFFF);
        stim_total = stim_total + 16'hFFFF;
        send_request(REQ_QUERY, 16'hFFFF, 32'd0);
        clear_table();
        send_request(REQ_QUERY, '0, 32'd0);

        // Random part: one phase per minimum setting, idling shifting between phases.
        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            set_min_len(min_settings[ph]);
            if (ph < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 73;
            end else if (ph < 4) begin
                send_idle_pct = 73;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // stall the receiver for a long stretch while items keep coming
            if (ph == 1)
                rx_hold_tog <= ~rx_hold_tog;
            run_random(RANDOM_PER_SETTING);
        end

        // Fill the table past its limit with short reads, querying along the way.
        clear_table();
        for (int k = 0; k < MAX_READS + 2; k++) begin
            append_read(LEN_W'($urandom_range(40)));
            if (k % 128 == 127)
                query_in_text();
        end
        repeat (4) query_in_text();

        drain();
        $display("Covered %0d requests: %0d appends, %0d queries, %0d clears, %0d unused codes,",
                 n_items, n_appends, n_queries, n_clears, n_unused);
        $display("across %0d minimum-length settings and one fill of all %0d table entries.",
                 N_SETTINGS + 1, MAX_READS);
        if (fail_count == 0) begin
            $display("** suffix_position_to_read_offset_core: PASSED **");
        end else begin
            $display("** suffix_position_to_read_offset_core: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sptro_pkg.sv
rtl/core/sptro_dp.sv
rtl/core/sptro_ctrl.sv
rtl/core/suffix_position_to_read_offset_core.sv
test/sptro_lookup_checker.sv
test/tb_top.sv
